### rtl/core/cigar_query_range_clipper_macros.svh
// ----------------------------------------------------------------------------
// cigar_query_range_clipper_macros.svh
// Assertion helpers for the cigar query range clipper RTL.
// ----------------------------------------------------------------------------
`ifndef CIGAR_QUERY_RANGE_CLIPPER_MACROS_SVH
`define CIGAR_QUERY_RANGE_CLIPPER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CQRC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CQRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cqrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqrc_pkg
// Types and constants of the cigar query range clipper.
// ----------------------------------------------------------------------------
package cqrc_pkg;

  // Widths
  localparam int COORD_WIDTH = 32;   // running query position
  localparam int WIN_WIDTH   = 32;   // window registers
  localparam int LEN_WIDTH   = 32;   // op length, kept length, span
  localparam int CODE_WIDTH  = 4;
  localparam int CFG_IDX_W   = 1;
  // Compare width: room for position plus length without wrap
  localparam int XW = ((COORD_WIDTH > WIN_WIDTH) ? COORD_WIDTH : WIN_WIDTH) + 1;

  // Op codes
  localparam logic [CODE_WIDTH-1:0] OPC_M  = 4'd0;
  localparam logic [CODE_WIDTH-1:0] OPC_I  = 4'd1;
  localparam logic [CODE_WIDTH-1:0] OPC_S  = 4'd4;
  localparam logic [CODE_WIDTH-1:0] OPC_EQ = 4'd7;
  localparam logic [CODE_WIDTH-1:0] OPC_X  = 4'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 1'd1;

  typedef struct packed {
    logic [CODE_WIDTH-1:0] op_code;
    logic [LEN_WIDTH-1:0]  op_length;
    logic                  final_op;
  } op_beat_t;

  typedef struct packed {
    logic                  kept_valid;
    logic [CODE_WIDTH-1:0] kept_code;
    logic [LEN_WIDTH-1:0]  kept_length;
    logic [LEN_WIDTH-1:0]  reference_span;
    logic                  final_result;
  } kept_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [WIN_WIDTH-1:0] wdata;
  } cfg_beat_t;

  // Running state carried from op to op
  typedef struct packed {
    logic [COORD_WIDTH-1:0] pos;
    logic [LEN_WIDTH-1:0]   span;
  } clip_state_t;

  // Query-consuming ops
  function automatic logic uses_query(input logic [CODE_WIDTH-1:0] code);
    return (code == OPC_M) || (code == OPC_I) || (code == OPC_S) ||
           (code == OPC_EQ) || (code == OPC_X);
  endfunction

endpackage

### rtl/core/cqrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqrc_if
// Valid/ready channels of the clipper: op input, kept output, config writes.
// ----------------------------------------------------------------------------
interface cqrc_in_if import cqrc_pkg::*;;
  logic     valid;
  logic     ready;
  op_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cqrc_out_if import cqrc_pkg::*;;
  logic       valid;
  logic       ready;
  kept_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cqrc_cfg_if import cqrc_pkg::*;;
  logic      valid;
  logic      ready;
  cfg_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/cqrc_trim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqrc_trim
// Combinational trim of one cigar op against the query window, with the
// next running position and span.
// ----------------------------------------------------------------------------
module cqrc_trim import cqrc_pkg::*; (
  input  op_beat_t               op,
  input  clip_state_t            cur,
  input  logic [WIN_WIDTH-1:0]   window_start,
  input  logic [WIN_WIDTH-1:0]   window_end,
  output kept_beat_t             res,
  output clip_state_t            nxt
);

  localparam logic [XW-1:0] COORD_MAX_X = {{(XW-COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}};

  logic [XW-1:0]        pos_x, cnt_x, ws_x, we_x, sum_x, next_x;
  logic [XW-1:0]        b_x, e_x, len_x;
  logic                 in_window, emit;
  logic [LEN_WIDTH-1:0] klen;
  logic [LEN_WIDTH:0]   span_sum;
  logic [LEN_WIDTH-1:0] span_upd;
  clip_state_t          upd;

  // Position after this op, saturating
  always_comb begin
    pos_x  = XW'(cur.pos);
    cnt_x  = XW'(op.op_length);
    ws_x   = XW'(window_start);
    we_x   = XW'(window_end);
    sum_x  = pos_x + cnt_x;
    if (!uses_query(op.op_code)) begin
      next_x = pos_x;
    end else if (sum_x > COORD_MAX_X) begin
      next_x = COORD_MAX_X;
    end else begin
      next_x = sum_x;
    end
  end

  // Cut points inside the op
  always_comb begin
    b_x = '0;
    e_x = cnt_x;
    if ((ws_x >= pos_x) && (ws_x < next_x)) begin
      b_x = ws_x - pos_x;
    end
    if ((we_x >= pos_x) && (we_x < next_x)) begin
      e_x = we_x - pos_x;
    end
    len_x     = e_x - b_x;
    in_window = (pos_x <= we_x);
    emit      = in_window && (next_x >= ws_x) && (e_x > b_x);
    klen      = len_x[LEN_WIDTH-1:0];
  end

  // Span update, saturating
  always_comb begin
    span_sum = {1'b0, cur.span} + {1'b0, klen};
    if (emit && (op.op_code != OPC_I)) begin
      span_upd = span_sum[LEN_WIDTH] ? {LEN_WIDTH{1'b1}} : span_sum[LEN_WIDTH-1:0];
    end else begin
      span_upd = cur.span;
    end
    upd.span = span_upd;
    upd.pos  = in_window ? next_x[COORD_WIDTH-1:0] : cur.pos;
  end

  // Result beat and state for the next op
  always_comb begin
    res.kept_valid     = emit;
    res.kept_code      = emit ? op.op_code : '0;
    res.kept_length    = emit ? klen : '0;
    res.reference_span = span_upd;
    res.final_result   = op.final_op;
    nxt                = op.final_op ? '0 : upd;
  end

endmodule

### rtl/core/cigar_query_range_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_query_range_clipper
// Trims a cigar, one op per beat, to a window of query coordinates and
// keeps a running reference span.
// ----------------------------------------------------------------------------
// Channel  Dir   Beat contents
// ops      in    op_code, op_length, final_op
// kept     out   kept_valid, kept_code, kept_length, reference_span, final_result
// cfg      in    index (0 window_start, 1 window_end), wdata
//
// One op per cycle sustained while the kept channel is ready; an op beat
// goes through the input register, trim logic and result register.
// The trim of each op and the update of position and span happen in the one
// cycle an op moves from the input register to the result register.
// A stalled kept channel holds the result register; one more op is still
// taken into the input register. Config is always ready.
// Synchronous reset clears windows, position, span and both valid flags.
// ----------------------------------------------------------------------------
`include "cigar_query_range_clipper_macros.svh"

module cigar_query_range_clipper import cqrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cqrc_in_if.sink   ops,
  cqrc_out_if.source kept,
  cqrc_cfg_if.sink  cfg
);

  logic                 inq_valid;
  op_beat_t             inq;
  logic                 outq_valid;
  kept_beat_t           outq;
  clip_state_t          state;
  clip_state_t          state_next;
  kept_beat_t           res;
  logic [WIN_WIDTH-1:0] window_start;
  logic [WIN_WIDTH-1:0] window_end;
  logic                 advance;

  // Move an op into the result register when it is free or being drained
  assign advance    = inq_valid && (!outq_valid || kept.ready);
  assign ops.ready  = !inq_valid || advance;
  assign kept.valid = outq_valid;
  assign kept.data  = outq;
  assign cfg.ready  = 1'b1;

  cqrc_trim u_trim (
    .op           (inq),
    .cur          (state),
    .window_start (window_start),
    .window_end   (window_end),
    .res          (res),
    .nxt          (state_next)
  );

  // Control, running state and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid    <= 1'b0;
      outq_valid   <= 1'b0;
      state        <= '0;
      window_start <= '0;
      window_end   <= '0;
    end else begin
      if (ops.valid && ops.ready) begin
        inq_valid <= 1'b1;
      end else if (advance) begin
        inq_valid <= 1'b0;
      end
      if (advance) begin
        outq_valid <= 1'b1;
        state      <= state_next;
      end else if (kept.ready) begin
        outq_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_WINDOW_START: window_start <= cfg.data.wdata;
          REG_WINDOW_END:   window_end   <= cfg.data.wdata;
          default:          ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ops.valid && ops.ready) begin
      inq <= ops.data;
    end
    if (advance) begin
      outq <= res;
    end
  end

  `CQRC_ASSERT_IMPL(a_kept_nonzero, clk, rst, outq_valid && outq.kept_valid, outq.kept_length != '0, "kept op with zero length")
  `CQRC_ASSERT_IMPL(a_drop_clean, clk, rst, outq_valid && !outq.kept_valid, (outq.kept_code == '0) && (outq.kept_length == '0), "dropped op carries code or length")
  `CQRC_ASSERT_NEXT(a_final_clears, clk, rst, advance && inq.final_op, (state.pos == '0) && (state.span == '0), "state not cleared after final op")
  `CQRC_ASSERT_NEXT(a_span_grows, clk, rst, advance && !inq.final_op, state.span >= $past(state.span), "span decreased within a cigar")
  `CQRC_ASSERT_IMPL(a_ready_when_empty, clk, rst, !outq_valid, ops.ready, "input stalled with empty result register")

endmodule

### test/cigar_clip_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_clip_monitor
// Watches the op, kept and config channels of the cigar query range clipper.
// Tracks its own window registers, query position and reference span, works
// out the trimmed op for every accepted op beat and compares each kept beat,
// field by field, against the oldest pending trimmed op.
// ----------------------------------------------------------------------------
module cigar_clip_monitor import cqrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  input  logic        op_ready,
  input  op_beat_t    op_beat,
  input  logic        out_valid,
  input  logic        out_ready,
  input  kept_beat_t  out_beat,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  cfg_beat_t   cfg_beat,
  output int unsigned fail_count,
  output int unsigned backlog
);

  localparam logic [63:0] POS_MAX  = (64'd1 << COORD_WIDTH) - 64'd1;
  localparam logic [63:0] SPAN_MAX = (64'd1 << LEN_WIDTH) - 64'd1;

  logic [WIN_WIDTH-1:0]   win_lo = '0;
  logic [WIN_WIDTH-1:0]   win_hi = '0;
  logic [COORD_WIDTH-1:0] qpos = '0;
  logic [LEN_WIDTH-1:0]   span_acc = '0;
  kept_beat_t             trimmed_q[$];
  int unsigned            kept_seen = 0;

  initial begin
    fail_count = 0;
    backlog = 0;
  end

  // Trim one op to the window and advance position and span
  function automatic kept_beat_t trim_op(op_beat_t b);
    logic [63:0] here, after, sum, cut_lo, cut_hi, piece;
    logic        consumes;
    kept_beat_t  r;
    r = '0;
    here = 64'(qpos);
    case (b.op_code)
      OPC_M, OPC_I, OPC_S, OPC_EQ, OPC_X: consumes = 1'b1;
      default: consumes = 1'b0;
    endcase
    sum = here + 64'(b.op_length);
    after = !consumes ? here : (sum > POS_MAX) ? POS_MAX : sum;
    // past the window end: nothing moves
    if (here <= 64'(win_hi)) begin
      if (after >= 64'(win_lo)) begin
        cut_lo = (64'(win_lo) >= here && 64'(win_lo) < after) ? 64'(win_lo) - here : 64'd0;
        cut_hi = (64'(win_hi) >= here && 64'(win_hi) < after) ?
                 64'(win_hi) - here : 64'(b.op_length);
        if (cut_hi > cut_lo) begin
          piece = cut_hi - cut_lo;
          r.kept_valid  = 1'b1;
          r.kept_code   = b.op_code;
          r.kept_length = piece[LEN_WIDTH-1:0];
          // insertions take no reference
          if (b.op_code != OPC_I) begin
            sum = 64'(span_acc) + 64'(piece[LEN_WIDTH-1:0]);
            span_acc = (sum > SPAN_MAX) ? SPAN_MAX[LEN_WIDTH-1:0] : sum[LEN_WIDTH-1:0];
          end
        end
      end
      qpos = after[COORD_WIDTH-1:0];
    end
    r.reference_span = span_acc;
    r.final_result   = b.final_op;
    if (b.final_op) begin
      qpos = '0;
      span_acc = '0;
    end
    return r;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (fail_count < 10)
        $display("ERROR kept beat %0d, %s: expected %0h, got %0h", kept_seen, field, want, got);
      fail_count++;
    end
  endfunction

  // Sample all three channels on the rising edge
  always @(posedge clk) begin
    kept_beat_t want;
    if (rst) begin
      win_lo = '0;
      win_hi = '0;
      qpos = '0;
      span_acc = '0;
      trimmed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_beat.index)
          REG_WINDOW_START: win_lo = cfg_beat.wdata;
          REG_WINDOW_END:   win_hi = cfg_beat.wdata;
          default: ;
        endcase
      end
      // append the predicted beat at the tail
      if (op_valid && op_ready)
        trimmed_q = {trimmed_q, trim_op(op_beat)};
      if (out_valid && out_ready) begin
        if (trimmed_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR kept beat %0d arrived with no op pending: %0h", kept_seen, out_beat);
          fail_count++;
        end else begin
          want = trimmed_q.pop_front();
          check_field("kept_valid", 64'(want.kept_valid), 64'(out_beat.kept_valid));
          check_field("kept_code", 64'(want.kept_code), 64'(out_beat.kept_code));
          check_field("kept_length", 64'(want.kept_length), 64'(out_beat.kept_length));
          check_field("reference_span", 64'(want.reference_span),
                      64'(out_beat.reference_span));
          check_field("final_result", 64'(want.final_result), 64'(out_beat.final_result));
        end
        kept_seen++;
      end
    end
    backlog = trimmed_q.size();
  end

endmodule

### test/cigar_query_range_clipper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_query_range_clipper_test
// Drives cigars into the clipper under a series of query windows: a short
// directed run over the op codes, window edges and saturation, then random
// cigars with idle gaps on both sides and two long kept-side stalls. The
// monitor checks every kept beat; this module reports the verdict.
// ----------------------------------------------------------------------------
module cigar_query_range_clipper_test;
  import cqrc_pkg::*;

  // Op codes with no package constant
  localparam logic [CODE_WIDTH-1:0] OP_D         = 4'd2;
  localparam logic [CODE_WIDTH-1:0] OP_N         = 4'd3;
  localparam logic [CODE_WIDTH-1:0] OP_H         = 4'd5;
  localparam logic [CODE_WIDTH-1:0] OP_P         = 4'd6;
  localparam logic [CODE_WIDTH-1:0] OP_UNK_FIRST = 4'd9;
  localparam logic [CODE_WIDTH-1:0] OP_UNK_LAST  = 4'd15;
  localparam logic [LEN_WIDTH-1:0]  LEN_MAX      = '1;
  localparam int unsigned OPS_PER_WINDOW = 65;
  localparam int unsigned LONG_STALL     = 60;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned fail_count;
  int unsigned backlog;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_request;

  cqrc_in_if  op_ch();
  cqrc_out_if kept_ch();
  cqrc_cfg_if cfg_ch();

  cigar_query_range_clipper DUT (
    .clk  (clk),
    .rst  (rst),
    .ops  (op_ch),
    .kept (kept_ch),
    .cfg  (cfg_ch)
  );

  cigar_clip_monitor u_clip_monitor (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (op_ch.valid),
    .op_ready   (op_ch.ready),
    .op_beat    (op_ch.data),
    .out_valid  (kept_ch.valid),
    .out_ready  (kept_ch.ready),
    .out_beat   (kept_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_beat   (cfg_ch.data),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #2_000_000;
    $display("cigar_query_range_clipper: mismatch");
    $finish;
  end

  // Kept-side ready: random idling, or a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    kept_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        kept_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        kept_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic op_beat_t mk_op(logic [CODE_WIDTH-1:0] code, logic [LEN_WIDTH-1:0] len,
                                     logic last);
    op_beat_t b;
    b.op_code = code;
    b.op_length = len;
    b.final_op = last;
    return b;
  endfunction

  // Offer one op beat; entered and left at a falling edge
  task automatic put_op(input op_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      op_ch.valid <= 1'b0;
      @(negedge clk);
    end
    op_ch.valid <= 1'b1;
    op_ch.data <= b;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write both window registers, start then end
  task automatic set_window(input logic [WIN_WIDTH-1:0] lo, input logic [WIN_WIDTH-1:0] hi);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= cfg_beat_t'{index: REG_WINDOW_START, wdata: lo};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.data <= cfg_beat_t'{index: REG_WINDOW_END, wdata: hi};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering and wait until every kept beat is back
  task automatic drain();
    op_ch.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One random cigar; wide makes huge lengths common
  task automatic send_cigar(input bit wide, inout int unsigned sent);
    int unsigned n;
    int unsigned r;
    bit          ends;
    op_beat_t    b;
    n = $urandom_range(1, 14);
    ends = ($urandom_range(9) != 0);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 6) b.op_code = CODE_WIDTH'($urandom_range(OP_UNK_FIRST, OP_UNK_LAST));
      else b.op_code = CODE_WIDTH'($urandom_range(OPC_M, OPC_X));
      r = $urandom_range(31);
      if (r < (wide ? 10 : 1)) b.op_length = $urandom;
      else if (r == 31) b.op_length = '0;
      else b.op_length = $urandom_range(1, 400);
      // stray end marks break some cigars early
      b.final_op = (ends && k == n - 1) || ($urandom_range(49) == 0);
      put_op(b);
      sent++;
    end
  endtask

  initial begin
    int unsigned sent;
    logic [WIN_WIDTH-1:0] lo, hi;
    rst = 1'b1;
    op_ch.valid = 1'b0;
    op_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every op code inside a small window, crossing both edges
    set_window(32'd5, 32'd20);
    put_op(mk_op(OPC_M, 32'd3, 1'b0));        // ends before the start
    put_op(mk_op(OPC_I, 32'd4, 1'b0));        // straddles the start
    put_op(mk_op(OP_D, 32'd6, 1'b0));
    put_op(mk_op(OPC_S, 32'd2, 1'b0));
    put_op(mk_op(OP_UNK_LAST, 32'd7, 1'b0));  // unknown code, no query use
    put_op(mk_op(OPC_M, 32'd0, 1'b0));        // zero length
    put_op(mk_op(OP_H, 32'd3, 1'b0));
    put_op(mk_op(OP_P, 32'd1, 1'b0));
    put_op(mk_op(OP_N, 32'd2, 1'b0));
    put_op(mk_op(OPC_EQ, 32'd5, 1'b0));
    put_op(mk_op(OPC_X, 32'd10, 1'b0));       // straddles the end
    put_op(mk_op(OPC_M, 32'd4, 1'b0));        // past the window
    put_op(mk_op(OPC_I, 32'd1, 1'b1));
    drain();

    // Full window: position and span saturation
    set_window('0, '1);
    put_op(mk_op(OPC_M, LEN_MAX, 1'b0));
    put_op(mk_op(OPC_I, LEN_MAX, 1'b0));
    put_op(mk_op(OP_D, LEN_MAX, 1'b0));
    put_op(mk_op(OP_UNK_FIRST, 32'd1, 1'b0));
    put_op(mk_op(OPC_X, 32'd5, 1'b1));
    drain();

    // Start beyond end, then an empty window, then both at the top
    set_window(32'd100, 32'd50);
    put_op(mk_op(OPC_M, 32'd80, 1'b0));
    put_op(mk_op(OPC_M, 32'd40, 1'b1));
    drain();
    set_window('0, '0);
    put_op(mk_op(OPC_M, 32'd5, 1'b0));
    put_op(mk_op(OP_D, 32'd3, 1'b1));
    drain();
    set_window('1, '1);
    put_op(mk_op(OPC_M, LEN_MAX, 1'b0));
    put_op(mk_op(OP_D, 32'd2, 1'b0));
    put_op(mk_op(OPC_S, 32'd9, 1'b1));
    drain();

    // Random cigars: three idling modes, four window styles each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int style = 0; style < 4; style++) begin
        case (style)
          0: begin
            lo = $urandom_range(0, 400);
            hi = lo + $urandom_range(0, 2500);
          end
          1: begin
            lo = '0;
            hi = '1;
          end
          2: begin
            lo = $urandom_range(0, 600);
            hi = $urandom_range(0, 600);
          end
          default: begin
            lo = $urandom;
            hi = $urandom;
          end
        endcase
        set_window(lo, hi);
        // long kept-side hold-off while ops keep coming
        if (style == 1 && phase != 1) stall_request = LONG_STALL;
        sent = 0;
        while (sent < OPS_PER_WINDOW) send_cigar(style == 3, sent);
        drain();
      end
    end

    if (fail_count == 0)
      $display("cigar_query_range_clipper: match");
    else
      $display("cigar_query_range_clipper: mismatch");
    $finish;
  end

endmodule
